[hdl/b64le_pkg.sv]
// Shared types, constants and the character mapping for the base64 line encoder.
`timescale 1ns / 1ps

package b64le_pkg;

    localparam int unsigned MAX_CHARS       = 5;
    localparam int unsigned CHAR_W          = 8;
    localparam int unsigned CNT_W           = 3;
    localparam int unsigned QUEUE_DEPTH_DEF = 2;

    localparam logic [7:0] LINE_LIMIT_RST = 8'd72;
    localparam logic [7:0] LF_CHAR        = 8'h0A;
    localparam logic [7:0] PAD_CHAR       = 8'h3D;

    // One queued job: the characters caused by a single input byte.
    typedef struct packed {
        logic [MAX_CHARS-1:0][CHAR_W-1:0] chars;
        logic [CNT_W-1:0]                 num;
        logic                             last;
    } job_t;

    localparam int unsigned JOB_W = $bits(job_t);

    typedef struct packed {
        logic push;
        logic pop;
    } q_ctrl_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    function automatic logic [7:0] b64_char(input logic [5:0] six);
        logic [7:0] s8;
        s8 = {2'b00, six};
        if (six < 6'd26)
        begin
            return s8 + 8'd65;
        end
        else if (six < 6'd52)
        begin
            return s8 + 8'd71;
        end
        else if (six < 6'd62)
        begin
            return s8 - 8'd4;
        end
        else if (six == 6'd62)
        begin
            return 8'h2B;
        end
        else
        begin
            return 8'h2F;
        end
    endfunction

endpackage

[hdl/b64le_front.sv]
// Front end: takes input bytes, keeps group and line state, and builds character jobs.
`timescale 1ns / 1ps

module b64le_front
    import b64le_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       last_byte,
    input  logic       cfg_valid,
    input  logic [7:0] cfg_data,
    input  q_stat_t    q_stat,
    output q_ctrl_t    q_push,
    output job_t       job
);

    logic [1:0] phase_reg, phase_next;
    logic [3:0] carry_reg, carry_next;
    logic [7:0] count_reg, count_next;
    logic [7:0] limit_reg;

    logic                             take;
    logic                             group_done;
    logic [8:0]                       cnt9;
    logic                             lf_mid;
    logic [7:0]                       cnt_base;
    logic [1:0]                       ph_after;
    logic [3:0]                       cr_after;
    logic [MAX_CHARS-1:0][CHAR_W-1:0] ch;
    logic [CNT_W-1:0]                 k;

    assign in_ready    = !q_stat.full;
    assign take        = in_valid && in_ready;
    assign q_push.push = take;
    assign q_push.pop  = 1'b0;

    always_comb
    begin
        ch         = '0;
        k          = '0;
        group_done = 1'b0;
        ph_after   = 2'd1;
        cr_after   = {2'b00, in_byte[1:0]};
        case (phase_reg)
            2'd1:
            begin
                ch[k]    = b64_char({carry_reg[1:0], in_byte[7:4]});
                k        = k + 3'd1;
                ph_after = 2'd2;
                cr_after = in_byte[3:0];
            end
            2'd2:
            begin
                ch[k]      = b64_char({carry_reg, in_byte[7:6]});
                k          = k + 3'd1;
                ch[k]      = b64_char(in_byte[5:0]);
                k          = k + 3'd1;
                ph_after   = 2'd0;
                cr_after   = 4'd0;
                group_done = 1'b1;
            end
            default:
            begin
                ch[k] = b64_char(in_byte[7:2]);
                k     = k + 3'd1;
            end
        endcase

        // Stored count never exceeds 252, so nine bits hold count plus four.
        cnt9   = {1'b0, count_reg} + 9'd4;
        lf_mid = group_done && (cnt9 >= {1'b0, limit_reg});
        if (lf_mid)
        begin
            ch[k] = LF_CHAR;
            k     = k + 3'd1;
        end
        cnt_base = group_done ? (lf_mid ? 8'd0 : cnt9[7:0]) : count_reg;

        if (last_byte)
        begin
            if (ph_after == 2'd1)
            begin
                ch[k] = b64_char({cr_after[1:0], 4'b0000});
                k     = k + 3'd1;
                ch[k] = PAD_CHAR;
                k     = k + 3'd1;
                ch[k] = PAD_CHAR;
                k     = k + 3'd1;
            end
            else if (ph_after == 2'd2)
            begin
                ch[k] = b64_char({cr_after, 2'b00});
                k     = k + 3'd1;
                ch[k] = PAD_CHAR;
                k     = k + 3'd1;
            end
            // A padded tail always leaves the line non-empty.
            if ((cnt_base != 8'd0) || (ph_after != 2'd0))
            begin
                ch[k] = LF_CHAR;
                k     = k + 3'd1;
            end
        end

        job.chars = ch;
        job.num   = k;
        job.last  = last_byte;
    end

    always_comb
    begin
        if (last_byte)
        begin
            phase_next = 2'd0;
            carry_next = 4'd0;
            count_next = 8'd0;
        end
        else
        begin
            phase_next = ph_after;
            carry_next = cr_after;
            count_next = cnt_base;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= 2'd0;
            carry_reg <= 4'd0;
            count_reg <= 8'd0;
            limit_reg <= LINE_LIMIT_RST;
        end
        else
        begin
            if (take)
            begin
                phase_reg <= phase_next;
                carry_reg <= carry_next;
                count_reg <= count_next;
            end
            if (cfg_valid)
            begin
                limit_reg <= cfg_data;
            end
        end
    end

endmodule

[hdl/b64le_queue.sv]
// Small job queue between the front end and the character output stage.
`timescale 1ns / 1ps

module b64le_queue
    import b64le_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  q_ctrl_t wr_ctrl,
    input  q_ctrl_t rd_ctrl,
    input  job_t    wr_job,
    output job_t    rd_job,
    output q_stat_t stat
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned FILL_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(DEPTH);

    job_t              slots_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic              do_wr, do_rd;

    assign stat.full  = (fill_reg == FILL_MAX);
    assign stat.empty = (fill_reg == '0);
    assign do_wr      = wr_ctrl.push && !stat.full;
    assign do_rd      = rd_ctrl.pop && !stat.empty;
    assign rd_job     = slots_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slots_reg[wr_ptr_reg] <= wr_job;
        end
    end

endmodule

[hdl/b64le_back.sv]
// Back end: walks the head job one character per cycle into the output register while the output is not stalled.
`timescale 1ns / 1ps

module b64le_back
    import b64le_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  job_t       head,
    input  q_stat_t    q_stat,
    output q_ctrl_t    q_pop,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_char,
    output logic       last_char
);

    logic [CNT_W-1:0] idx_reg, idx_next;
    logic             valid_reg, valid_next;
    logic [7:0]       char_reg;
    logic             last_reg;
    logic             load;
    logic             at_end;

    assign load       = !q_stat.empty && (!valid_reg || out_ready);
    assign at_end     = (idx_reg == (head.num - 3'd1));
    assign q_pop.pop  = load && at_end;
    assign q_pop.push = 1'b0;

    assign out_valid = valid_reg;
    assign out_char  = char_reg;
    assign last_char = last_reg;

    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
            idx_next   = at_end ? '0 : idx_reg + 3'd1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            char_reg <= head.chars[idx_reg];
            last_reg <= head.last && at_end;
        end
    end

endmodule

[hdl/base64_line_encoder.sv]
// Top level of the base64 encoder with line breaks.
//
//  Channel  Direction  Payload                        Handshake
//  s_*      in         tdata = in_byte, tlast = last  tvalid / tready
//  m_*      out        tdata = out_char, tlast = last tvalid / tready
//  cfg_*    in         cfg_data = line_limit          cfg_valid / cfg_ready
//
// The input side takes one byte per cycle while the job queue has room.
// The output side sends one character per cycle while one is waiting and
// m_tready is high; a byte causes one to four characters (about 1.35 on average).
// Reset clears the group phase, leftover bits and line count, and sets the
// line limit to 72. Either side may stall; the queue absorbs the difference.
`timescale 1ns / 1ps

module base64_line_encoder
    import b64le_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_char
    output logic       m_tlast,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_data
);

    q_stat_t q_stat;
    q_ctrl_t front_ctrl;
    q_ctrl_t back_ctrl;
    job_t    new_job;
    job_t    head_job;

    assign cfg_ready = 1'b1;

    b64le_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_byte   (s_tdata),
        .last_byte (s_tlast),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .q_stat    (q_stat),
        .q_push    (front_ctrl),
        .job       (new_job)
    );

    b64le_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_ctrl (front_ctrl),
        .rd_ctrl (back_ctrl),
        .wr_job  (new_job),
        .rd_job  (head_job),
        .stat    (q_stat)
    );

    b64le_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head_job),
        .q_stat    (q_stat),
        .q_pop     (back_ctrl),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_char  (m_tdata),
        .last_char (m_tlast)
    );

endmodule
